FILE: src/smmmm_pkg.sv
package smmmm_pkg;

   localparam int MAX_COUNT_DEFAULT  = 64;
   localparam int VALUE_BITS_DEFAULT = 16;

   typedef enum logic {
      ST_LOAD,
      ST_CALC
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

FILE: src/smmmm_cell.sv
module smmmm_cell #(
   parameter int VALUE_BITS = smmmm_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  smmmm_pkg::cell_ctrl_type  ctrl,
   input  logic                      occupied,
   input  logic [VALUE_BITS-1:0]     new_value,
   input  logic                      prev_gt,
   input  logic [VALUE_BITS-1:0]     prev_value,
   input  logic [VALUE_BITS-1:0]     next_value,
   output logic [VALUE_BITS-1:0]     value_out,
   output logic                      gt_out
);

   logic [VALUE_BITS-1:0] data_ff;
   logic [VALUE_BITS-1:0] data_in;

   // empty cells count as greater, so a new sample lands after equal ones
   assign gt_out    = !occupied || (data_ff > new_value);
   assign value_out = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (gt_out) begin
            data_in = prev_gt ? prev_value : new_value;
         end
      end else if (ctrl.shift) begin
         data_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: src/smmmm_div.sv
module smmmm_div #(
   parameter int DIVIDEND_BITS = 22,
   parameter int DIVISOR_BITS  = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     ge;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_BITS'(DIVIDEND_BITS);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/set_min_max_mean_median_unit.sv
// Set statistics unit.
// Request channel (req_valid/req_ready, req_value, req_last) takes one sample
// per transaction; req_last closes the set. One response transaction
// (rsp_valid/rsp_ready) follows each closed set with min, max, truncated mean,
// doubled median, kept count and an overflow flag (samples past MAX_COUNT
// are dropped).
// Samples load at one per cycle into a sorted insertion chain of MAX_COUNT
// cells. After the last sample the unit enters a compute phase: a
// one-bit-per-cycle restoring divider forms the mean (SUM_BITS =
// VALUE_BITS + log2(MAX_COUNT), 22 by default) while the chain shifts
// toward cell 0 to pick out the median. The response register loads at the
// end of that phase, once both the mean and the median are ready.
// req_ready is low only during that compute phase. The response sits in its
// own register, so loading of the next set proceeds while rsp_ready is low;
// a following set waits at the end of its compute phase until the response
// register frees. Reset (synchronous, active high) empties the set and
// drops any pending response.
module set_min_max_mean_median_unit #(
   parameter int MAX_COUNT  = smmmm_pkg::MAX_COUNT_DEFAULT,
   parameter int VALUE_BITS = smmmm_pkg::VALUE_BITS_DEFAULT,
   localparam int CNT_BITS  = $clog2(MAX_COUNT + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_min_value,
   output logic [VALUE_BITS-1:0] rsp_max_value,
   output logic [VALUE_BITS-1:0] rsp_mean_value,
   output logic [VALUE_BITS:0]   rsp_median_doubled,
   output logic [CNT_BITS-1:0]   rsp_item_count,
   output logic                  rsp_overflow
);

   localparam int SUM_BITS = VALUE_BITS + $clog2(MAX_COUNT);

   smmmm_pkg::state_type     state_ff, state_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0]    min_ff, min_in;
   logic [VALUE_BITS-1:0]    max_ff, max_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic                     drop_ff, drop_in;
   logic [CNT_BITS-1:0]      step_ff, step_in;
   logic [VALUE_BITS-1:0]    lo_ff, lo_in;
   logic [VALUE_BITS-1:0]    hi_ff, hi_in;
   logic                     med_done_ff, med_done_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_min_ff, rsp_min_in;
   logic [VALUE_BITS-1:0]    rsp_max_ff, rsp_max_in;
   logic [VALUE_BITS-1:0]    rsp_mean_ff, rsp_mean_in;
   logic [VALUE_BITS:0]      rsp_med_ff, rsp_med_in;
   logic [CNT_BITS-1:0]      rsp_count_ff, rsp_count_in;
   logic                     rsp_drop_ff, rsp_drop_in;

   logic                     accept;
   logic                     room;
   logic                     div_start;
   logic                     div_done;
   logic [SUM_BITS-1:0]      quotient;
   logic [CNT_BITS-1:0]      half;
   logic [VALUE_BITS:0]      median;
   smmmm_pkg::cell_ctrl_type cell_ctrl;

   logic [VALUE_BITS-1:0]    cell_value [MAX_COUNT];
   logic                     cell_gt    [MAX_COUNT];

   assign req_ready = (state_ff == smmmm_pkg::ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign room      = count_ff < CNT_BITS'(MAX_COUNT);
   assign half      = count_ff >> 1;
   assign median    = count_ff[0] ? {hi_ff, 1'b0} : ({1'b0, lo_ff} + {1'b0, hi_ff});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      drop_in      = drop_ff;
      step_in      = step_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      med_done_in  = med_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_count_in = rsp_count_ff;
      rsp_drop_in  = rsp_drop_ff;
      div_start    = 1'b0;
      cell_ctrl    = '0;
      unique case (state_ff)
         smmmm_pkg::ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  cell_ctrl.insert = 1'b1;
                  if (count_ff == '0 || req_value < min_ff) begin
                     min_in = req_value;
                  end
                  if (count_ff == '0 || req_value > max_ff) begin
                     max_in = req_value;
                  end
                  sum_in   = sum_ff + SUM_BITS'(req_value);
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  state_in    = smmmm_pkg::ST_CALC;
                  div_start   = 1'b1;
                  step_in     = '0;
                  med_done_in = 1'b0;
               end
            end
         end
         smmmm_pkg::ST_CALC: begin
            // cell 0 holds the sorted entry whose index is step_ff
            if (!med_done_ff) begin
               cell_ctrl.shift = 1'b1;
               step_in         = step_ff + CNT_BITS'(1);
               if (!count_ff[0] && step_ff == half - CNT_BITS'(1)) begin
                  lo_in = cell_value[0];
               end
               if (step_ff == half) begin
                  hi_in       = cell_value[0];
                  med_done_in = 1'b1;
               end
            end else if (div_done && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = min_ff;
               rsp_max_in   = max_ff;
               rsp_mean_in  = quotient[VALUE_BITS-1:0];
               rsp_med_in   = median;
               rsp_count_in = count_ff;
               rsp_drop_in  = drop_ff;
               state_in     = smmmm_pkg::ST_LOAD;
               count_in     = '0;
               min_in       = '1;
               max_in       = '0;
               sum_in       = '0;
               drop_in      = 1'b0;
            end
         end
         default: begin
            state_in = smmmm_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_med_ff   <= rsp_med_in;
      rsp_count_ff <= rsp_count_in;
      rsp_drop_ff  <= rsp_drop_in;
      if (reset) begin
         state_ff     <= smmmm_pkg::ST_LOAD;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         med_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         drop_ff      <= drop_in;
         med_done_ff  <= med_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   smmmm_div #(
      .DIVIDEND_BITS(SUM_BITS),
      .DIVISOR_BITS (CNT_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(sum_in),
      .divisor (count_in),
      .done    (div_done),
      .quotient(quotient)
   );

   for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
      logic                  occupied;
      logic                  prev_gt;
      logic [VALUE_BITS-1:0] prev_value;
      logic [VALUE_BITS-1:0] next_value;

      assign occupied = count_ff > CNT_BITS'(i);

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_value = req_value;
      end else begin : g_body
         assign prev_gt    = cell_gt[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == MAX_COUNT - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      smmmm_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .occupied  (occupied),
         .new_value (req_value),
         .prev_gt   (prev_gt),
         .prev_value(prev_value),
         .next_value(next_value),
         .value_out (cell_value[i]),
         .gt_out    (cell_gt[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_min_value      = rsp_min_ff;
   assign rsp_max_value      = rsp_max_ff;
   assign rsp_mean_value     = rsp_mean_ff;
   assign rsp_median_doubled = rsp_med_ff;
   assign rsp_item_count     = rsp_count_ff;
   assign rsp_overflow       = rsp_drop_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_COUNT))
      else $error("kept count exceeds capacity");

   a_calc_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smmmm_pkg::ST_CALC) |-> (count_ff != '0))
      else $error("compute phase with an empty set");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("running min above running max");

   a_rsp_after_calc: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> ($past(state_ff) == smmmm_pkg::ST_CALC))
      else $error("response loaded outside compute phase");
`endif

endmodule
